[sv/dictionary_word_expander_core_macros.svh]
// ----------------------------------------------------------------------------
// Dictionary word expander assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DICTIONARY_WORD_EXPANDER_CORE_MACROS_SVH
`define DICTIONARY_WORD_EXPANDER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define DWE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("dictionary word expander check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define DWE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("dictionary word expander check failed");

`endif

[sv/dwe_pkg.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander package
// Types, character codes and control structures shared by the block.
// ----------------------------------------------------------------------------
package dwe_pkg;

    // Character codes with a special meaning in the compressed stream.
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_AT    = 8'h40;

    // Parsing phase of the current book.
    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_ESCAPE = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DECODE = 2'd1,
        ST_LENGTH = 2'd2,
        ST_EXPAND = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_item;
        logic decode_item;
        logic load_literal;
        logic start_word;
        logic emit_byte;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_literal;
        logic is_expand;
        logic word_empty;
        logic byte_last;
        logic out_free;
    } t_dp_stat;

endpackage

[sv/dictionary_word_expander_core.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander core
// Decodes a dictionary-compressed book one byte per transaction.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_in_byte and i_start_of_book. A
// transaction completes when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with o_out_byte and o_run_last, which
// flags the final output byte caused by one input transaction.
// Each input byte is captured in the idle state and then decoded. A
// literal body byte is loaded into the output register as it is decoded.
// An escape index passes through the decode, length and expand states,
// paced by the registered reads of the length store and then the text store.
// The output register decouples the two sides, so a new input byte is
// captured while a result waits; a literal stays in decode and an expansion
// pauses while the receiver stalls, with the payload held steady.
// Reset clears the parse state to header phase and empties the output;
// the word stores need no clearing, as only words of the current book
// are ever read.
// ----------------------------------------------------------------------------
`include "dictionary_word_expander_core_macros.svh"

module dictionary_word_expander_core #(
    parameter int NUM_WORDS    = 255,
    parameter int MAX_WORD_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_book,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import dwe_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // Sequencer.
    dwe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // Parse state, word stores and output register.
    dwe_datapath #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_byte       (i_in_byte),
        .i_start_of_book (i_start_of_book),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last)
    );

    // A captured transaction keeps the block busy for its decode cycle.
    `DWE_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall)
    // Results are only produced while an item is being worked on.
    `DWE_ASSERT_SAME(a_result_from_work, $rose(o_valid), $past(o_stall))
    // A non-final word byte means the expansion is still running.
    `DWE_ASSERT_SAME(a_expand_busy, o_valid && !o_run_last, o_stall)

endmodule

[sv/dwe_ctrl.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander controller
// Sequences item intake, decoding and word expansion for the datapath.
// ----------------------------------------------------------------------------
module dwe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  dwe_pkg::t_dp_stat i_stat,
    output logic              o_stall,
    output dwe_pkg::t_ctl_cmd o_cmd
);
    import dwe_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_state         = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_stat.is_literal) begin
                    // A literal waits here until the output register frees up.
                    if (i_stat.out_free) begin
                        o_cmd.decode_item  = 1'b1;
                        o_cmd.load_literal = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end else if (i_stat.is_expand) begin
                    o_cmd.decode_item = 1'b1;
                    n_state           = ST_LENGTH;
                end else begin
                    o_cmd.decode_item = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_LENGTH: begin
                o_cmd.start_word = 1'b1;
                n_state          = i_stat.word_empty ? ST_IDLE : ST_EXPAND;
            end
            ST_EXPAND: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_stat.byte_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/dwe_datapath.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander datapath
// Holds the parse state, the word stores and the output register.
// ----------------------------------------------------------------------------
module dwe_datapath #(
    parameter int NUM_WORDS    = 255,
    parameter int MAX_WORD_LEN = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_in_byte,
    input  logic              i_start_of_book,
    input  logic              i_stall,
    input  dwe_pkg::t_ctl_cmd i_cmd,
    output dwe_pkg::t_dp_stat o_stat,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last
);
    import dwe_pkg::*;

    localparam int KW     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
    localparam int LW     = $clog2(MAX_WORD_LEN + 1);
    localparam int IAW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CW     = $clog2(NUM_WORDS + 1);
    localparam int BDEPTH = NUM_WORDS * (1 << KW);
    localparam int AW     = IAW + KW;

    // Item register and parse state.
    logic [7:0]    r_byte;
    logic          r_sob;
    t_phase        r_phase;
    t_phase        n_phase;
    logic [CW-1:0] r_word_count;
    logic [CW-1:0] n_word_count;
    logic [LW-1:0] r_fill;
    logic [LW-1:0] n_fill;

    // Word stores.
    logic [7:0]    mem_bytes [0:BDEPTH-1];
    logic [LW-1:0] mem_lens  [0:NUM_WORDS-1];

    // Expansion registers.
    logic [IAW-1:0] r_idx;
    logic [LW-1:0]  r_len_rd;
    logic [LW-1:0]  r_len;
    logic [LW-1:0]  r_k;
    logic [7:0]     r_rd_byte;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    // Decode signals.
    t_phase        ph_eff;
    logic [CW-1:0] wc_eff;
    logic [LW-1:0] fill_eff;
    logic [7:0]    idx8;
    logic          is_comma;
    logic          is_gt;
    logic          is_at;
    logic          is_zero;
    logic          wc_room;
    logic          fill_room;
    logic          close_word;
    logic          store_byte;
    logic [LW-1:0] k_next;
    logic [AW-1:0] rd_addr;

    // A start marker makes the item see a fresh header phase.
    always_comb begin
        ph_eff     = r_sob ? PH_HEADER : r_phase;
        wc_eff     = r_sob ? '0 : r_word_count;
        fill_eff   = r_sob ? '0 : r_fill;
        idx8       = r_byte - 8'd1;
        is_comma   = (r_byte == CHAR_COMMA);
        is_gt      = (r_byte == CHAR_GT);
        is_at      = (r_byte == CHAR_AT);
        is_zero    = (r_byte == 8'd0);
        wc_room    = (wc_eff < CW'(NUM_WORDS));
        fill_room  = (fill_eff < LW'(MAX_WORD_LEN));
        close_word = (ph_eff == PH_HEADER) && (is_comma || is_gt);
        store_byte = (ph_eff == PH_HEADER) && !is_comma && !is_gt && wc_room && fill_room;
        k_next     = r_k + LW'(1);
        rd_addr    = i_cmd.start_word ? {r_idx, KW'(0)} : {r_idx, k_next[KW-1:0]};
    end

    // Status toward the controller.
    always_comb begin
        o_stat.is_literal = (ph_eff == PH_BODY) && !is_at && !is_zero;
        o_stat.is_expand  = (ph_eff == PH_ESCAPE) && !is_zero && (idx8 < 8'(wc_eff));
        o_stat.word_empty = (r_len_rd == '0);
        o_stat.byte_last  = (k_next == r_len);
        o_stat.out_free   = !r_out_valid || !i_stall;
    end

    // Parse state update, applied once per item.
    always_comb begin
        n_phase      = r_phase;
        n_word_count = r_word_count;
        n_fill       = r_fill;
        if (i_cmd.decode_item) begin
            n_phase      = ph_eff;
            n_word_count = wc_eff;
            n_fill       = fill_eff;
            unique case (ph_eff)
                PH_HEADER: begin
                    if (close_word) begin
                        if (wc_room) begin
                            n_word_count = wc_eff + CW'(1);
                        end
                        n_fill = '0;
                        if (is_gt) begin
                            n_phase = PH_BODY;
                        end
                    end else if (store_byte) begin
                        n_fill = fill_eff + LW'(1);
                    end
                end
                PH_BODY: begin
                    if (is_at) begin
                        n_phase = PH_ESCAPE;
                    end else if (is_zero) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_ESCAPE: begin
                    n_phase = PH_BODY;
                end
                PH_DONE: begin
                    n_phase = PH_DONE;
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end
    end

    // Control state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_word_count <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_word_count <= n_word_count;
            r_fill       <= n_fill;
            if (i_cmd.load_literal || i_cmd.emit_byte) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture and expansion counters.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_byte <= i_in_byte;
            r_sob  <= i_start_of_book;
        end
        if (i_cmd.decode_item && o_stat.is_expand) begin
            r_idx <= idx8[IAW-1:0];
        end
        if (i_cmd.start_word) begin
            r_len <= r_len_rd;
            r_k   <= '0;
        end else if (i_cmd.emit_byte) begin
            r_k <= k_next;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_literal) begin
            r_out_byte <= r_byte;
            r_out_last <= 1'b1;
        end else if (i_cmd.emit_byte) begin
            r_out_byte <= r_rd_byte;
            r_out_last <= o_stat.byte_last;
        end
    end

    // Word text store: written in the header, read one byte per cycle while the output register is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode_item && store_byte) begin
            mem_bytes[{wc_eff[IAW-1:0], fill_eff[KW-1:0]}] <= r_byte;
        end
        if (i_cmd.start_word || i_cmd.emit_byte) begin
            r_rd_byte <= mem_bytes[rd_addr];
        end
    end

    // Word length store: written when a word closes, read on an escape.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode_item && close_word && wc_room) begin
            mem_lens[wc_eff[IAW-1:0]] <= fill_eff;
        end
        if (i_cmd.decode_item && o_stat.is_expand) begin
            r_len_rd <= mem_lens[idx8[IAW-1:0]];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

endmodule

[test/dictionary_word_expander_core_checker.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander checker
// Watches both channels of the expander, keeps its own copy of the book
// parse state and the word dictionary, predicts the text that every input
// transaction must produce and compares each output transaction with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dictionary_word_expander_core_checker #(
    parameter int NUM_WORDS    = 255,
    parameter int MAX_WORD_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_start,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_fail_count,
    output int         o_pending
);

    // One byte of expected decompressed text.
    typedef struct packed {
        logic [7:0] text;
        logic       last;
    } t_text_byte;

    t_text_byte      expected_text [$];
    dwe_pkg::t_phase book_phase;
    logic [7:0]      words_stored;
    logic [6:0]      word_fill;
    logic [7:0]      word_text [0:NUM_WORDS-1][0:MAX_WORD_LEN-1];
    logic [6:0]      word_len  [0:NUM_WORDS-1];
    int              errors;

    initial begin
        errors       = 0;
        book_phase   = dwe_pkg::PH_HEADER;
        words_stored = '0;
        word_fill    = '0;
    end

    // A full dictionary silently drops the word being closed.
    task automatic close_word();
        if (words_stored < NUM_WORDS) begin
            word_len[words_stored] = word_fill;
            words_stored++;
        end
        word_fill = '0;
    endtask

    // Advances the book parse by one byte and queues the text it produces.
    task automatic decode_book_byte(input logic [7:0] b, input logic sob);
        int idx;
        int len;
        int k;
        if (sob) begin
            book_phase   = dwe_pkg::PH_HEADER;
            words_stored = '0;
            word_fill    = '0;
        end
        case (book_phase)
            dwe_pkg::PH_HEADER: begin
                if (b == dwe_pkg::CHAR_COMMA) begin
                    close_word();
                end else if (b == dwe_pkg::CHAR_GT) begin
                    close_word();
                    book_phase = dwe_pkg::PH_BODY;
                end else if (words_stored < NUM_WORDS && word_fill < MAX_WORD_LEN) begin
                    // Everything else is word text; bytes past the limit are lost.
                    word_text[words_stored][word_fill] = b;
                    word_fill++;
                end
            end
            dwe_pkg::PH_BODY: begin
                if (b == dwe_pkg::CHAR_AT) begin
                    book_phase = dwe_pkg::PH_ESCAPE;
                end else if (b == 8'h00) begin
                    book_phase = dwe_pkg::PH_DONE;
                end else begin
                    expected_text.push_back('{text: b, last: 1'b1});
                end
            end
            dwe_pkg::PH_ESCAPE: begin
                // The index byte is taken as is, whatever its value.
                book_phase = dwe_pkg::PH_BODY;
                idx = int'(b) - 1;
                if (b != 8'h00 && idx < int'(words_stored)) begin
                    len = int'(word_len[idx]);
                    for (k = 0; k < len; k++) begin
                        expected_text.push_back('{text: word_text[idx][k],
                                                  last: (k == len - 1)});
                    end
                end
            end
            default: begin
                // A finished book ignores everything until the next start.
            end
        endcase
    endtask

    // Compare output transactions first, then fold in the input transaction.
    always @(posedge i_clk) begin
        t_text_byte want;
        if (!i_rst_n) begin
            book_phase   = dwe_pkg::PH_HEADER;
            words_stored = '0;
            word_fill    = '0;
            expected_text.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected output: out_byte %h run_last %b",
                           i_out_byte, i_out_last);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_out_byte !== want.text) begin
                        $error("out_byte: expected %h, actual %h", want.text, i_out_byte);
                        errors++;
                    end
                    if (i_out_last !== want.last) begin
                        $error("run_last: expected %b, actual %b", want.last, i_out_last);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_book_byte(i_in_byte, i_in_start);
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_text.size();
    end

endmodule

[test/dictionary_word_expander_core_tb.sv]
// ----------------------------------------------------------------------------
// Dictionary word expander testbench
// Feeds the expander directed and random compressed books with random gaps
// on the input and random backpressure on the output, and reports the
// verdict from the failure count of the checker beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dictionary_word_expander_core_tb;

    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_in_byte;
    logic       i_start_of_book;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    int fail_count;
    int expected_left;
    int items_sent;
    bit sender_calm;
    bit receiver_calm;
    bit hold_request;

    dictionary_word_expander_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_in_byte       (i_in_byte),
        .i_start_of_book (i_start_of_book),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_byte      (o_out_byte),
        .o_run_last      (o_run_last)
    );

    dictionary_word_expander_core_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_in_byte),
        .i_in_start   (i_start_of_book),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_run_last),
        .o_fail_count (fail_count),
        .o_pending    (expected_left)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    // Offers one byte after a random gap and holds it until the transaction.
    task automatic send_byte(input logic [7:0] b, input logic sob);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_in_byte       <= b;
        i_start_of_book <= sob;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Random word text: any byte but the two header delimiters.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == dwe_pkg::CHAR_COMMA || b == dwe_pkg::CHAR_GT) begin
            b = b ^ 8'h01;
        end
        return b;
    endfunction

    // Sender pause until every predicted byte has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_left != 0) @(posedge i_clk);
    endtask

    // One book: a header of words, then a body of literals and escapes.
    // A broken book stops before the closing '>' of its header.
    task automatic send_book(input int n_words, input int min_len, input int max_len,
                             input int n_body, input bit broken);
        int         len;
        int         w;
        int         k;
        int         stored;
        logic       first;
        logic [7:0] b;
        first = 1'b1;
        for (w = 0; w < n_words; w++) begin
            len = $urandom_range(min_len, max_len);
            for (k = 0; k < len; k++) begin
                send_byte(text_byte(), first);
                first = 1'b0;
            end
            if (w < n_words - 1) begin
                send_byte(dwe_pkg::CHAR_COMMA, first);
            end else if (!broken) begin
                send_byte(dwe_pkg::CHAR_GT, first);
            end
            first = 1'b0;
        end
        if (broken) return;

        stored = (n_words < 255) ? n_words : 255;
        for (k = 0; k < n_body; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    // Literal byte.
                    b = 8'($urandom_range(1, 255));
                    if (b == dwe_pkg::CHAR_AT) b = 8'h41;
                    send_byte(b, 1'b0);
                end
                5, 6, 7: begin
                    // Escape to a stored word, the end points favored.
                    send_byte(dwe_pkg::CHAR_AT, 1'b0);
                    case ($urandom_range(0, 3))
                        0:       b = 8'd1;
                        1:       b = 8'(stored);
                        default: b = 8'($urandom_range(1, stored));
                    endcase
                    send_byte(b, 1'b0);
                end
                8: begin
                    // Escape with an index that names no word, or any index.
                    send_byte(dwe_pkg::CHAR_AT, 1'b0);
                    case ($urandom_range(0, 2))
                        0:       b = 8'h00;
                        1:       b = (stored < 255) ? 8'($urandom_range(stored + 1, 255))
                                                    : 8'h00;
                        default: b = 8'($urandom_range(0, 255));
                    endcase
                    send_byte(b, 1'b0);
                end
                default: begin
                    // Noise, which may also end the book early.
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            send_byte(8'h00, 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int goal;
        int book;
        i_valid         = 1'b0;
        i_in_byte       = 8'h00;
        i_start_of_book = 1'b0;
        items_sent      = 0;
        hold_request    = 1'b0;
        sender_calm     = 1'b0;
        i_rst_n         = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header: a word holding zero, '@' and all ones, an empty word, a short word.
        send_byte(8'h00, 1'b1);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(dwe_pkg::CHAR_COMMA, 1'b0);
        send_byte(dwe_pkg::CHAR_COMMA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(dwe_pkg::CHAR_GT, 1'b0);
        // Literal extremes, then each word, then indices that name nothing.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h04, 1'b0);
        // End of book, a byte that is ignored, then a book of one empty word.
        send_byte(8'h00, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(dwe_pkg::CHAR_GT, 1'b1);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(dwe_pkg::CHAR_AT, 1'b0);
        send_byte(8'hFF, 1'b0);

        goal = items_sent + RANDOM_ITEMS;
        book = 0;
        while (items_sent < goal) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            if (book == 1) begin
                // Literal-rich book offered back to back during a long output hold.
                hold_request = 1'b1;
                sender_calm  = 1'b1;
                send_book(3, 0, 4, 40, 1'b0);
            end else if (book == 3) begin
                // A word around and beyond the length limit.
                send_book(1, 63, 70, 12, 1'b0);
            end else begin
                send_book($urandom_range(1, 8), 0, 6, $urandom_range(4, 20),
                          $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 4) == 0) wait_drained();
            book++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_left == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Receiver: a random hold before each output transaction, calm stretches,
    // and one long hold when the sender asks for it.
    initial begin
        int w;
        int taken;
        bit hold_done;
        i_stall       = 1'b1;
        receiver_calm = 1'b0;
        taken         = 0;
        hold_done     = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (taken % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            w = receiver_calm ? 0 : $urandom_range(0, 6);
            if (hold_request && !hold_done) begin
                w         = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            taken++;
        end
    end

endmodule
